/* src/eth_ip_l4_header_parser_assert.svh */
// Assertion macros for the file that carries concurrent checks.
`ifndef ETH_IP_L4_HEADER_PARSER_ASSERT_SVH
`define ETH_IP_L4_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH
`define EIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define EIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define EIP_ASSERT(label, prop, msg)
`define EIP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* src/eip_pkg.sv */
package eip_pkg;

  localparam int MAX_FRAME_BYTES = 65535;
  localparam int MAX_TAGS        = 2;

  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 17;
  localparam int LEN_W     = 16;
  localparam int PORT_W    = 16;
  localparam int PROTO_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int FRAG_W    = 14;
  localparam int TCP_OFF_W = 4;
  localparam int IHL_W     = 6;

  localparam int ETH_HDR_BYTES = 14;
  localparam int TAG_BYTES     = 4;
  localparam int IPV4_MIN_HDR  = 20;
  localparam int IPV6_HDR      = 40;
  localparam int IP_HDR_MAX    = 60;
  localparam int UDP_HDR       = 8;
  localparam int TCP_MIN_HDR   = 20;

  localparam int L3_MAX = ETH_HDR_BYTES + TAG_BYTES * MAX_TAGS;
  localparam int L3_W   = $clog2(L3_MAX + 1);
  localparam int L4_W   = $clog2(L3_MAX + IP_HDR_MAX + 1);
  localparam int TAG_W  = $clog2(MAX_TAGS + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] ET_CTAG = 16'h8100;
  localparam logic [15:0] ET_STAG = 16'h88a8;
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86dd;

  localparam logic [3:0] IP_VER4 = 4'd4;
  localparam logic [3:0] IP_VER6 = 4'd6;

  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  // Byte offsets of captured fields within their headers.
  localparam int V4_OFF_TOTAL = 2;
  localparam int V4_OFF_FRAG  = 6;
  localparam int V4_OFF_PROTO = 9;
  localparam int V6_OFF_PLEN  = 4;
  localparam int V6_OFF_NEXT  = 6;
  localparam int L4_OFF_PORT  = 2;
  localparam int L4_OFF_LEN   = 4;
  localparam int L4_OFF_TCPDO = 12;

  typedef enum logic [1:0] {
    DEC_NONE        = 2'd0,
    DEC_MALFORMED   = 2'd2,
    DEC_UNSUPPORTED = 2'd3
  } dec_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PARSED      = 2'd0,
    ST_MALFORMED   = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]     len;
    logic [L3_W-1:0]      l3_start;
    dec_t                 decided;
    logic                 is_v4;
    logic                 is_v6;
    logic [IHL_W-1:0]     ip_header_len;
    logic [LEN_W-1:0]     ip_total_len;
    logic                 frag_nz;
    logic [PROTO_W-1:0]   protocol;
    logic [LEN_W-1:0]     udp_len;
    logic [TCP_OFF_W-1:0] tcp_offset;
    logic [PORT_W-1:0]    port;
  } eip_snap_t;

endpackage

/* src/eip_in_if.sv */
interface eip_in_if import eip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* src/eip_out_if.sv */
interface eip_out_if import eip_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PROTO_W-1:0]  l4_protocol;
  logic [PORT_W-1:0]   dest_port;
  logic [LEN_W-1:0]    payload_offset;
  logic [LEN_W-1:0]    payload_length;

  modport source (output valid, output status, output l4_protocol, output dest_port,
                  output payload_offset, output payload_length, input ready);
  modport sink (input valid, input status, input l4_protocol, input dest_port,
                input payload_offset, input payload_length, output ready);
endinterface

/* src/eip_capture.sv */
module eip_capture import eip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  eip_in_if.sink    in_ch,
  input  logic      out_full,
  input  logic      snap_take,
  output logic      snap_v,
  output eip_snap_t snap
);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [15:0]          et_r, et_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [L3_W-1:0]      l3_r, l3_nxt;
  logic [IHL_W-1:0]     ihl_r, ihl_nxt;
  logic [LEN_W-1:0]     total_r, total_nxt;
  logic [FRAG_W-1:0]    frag_r, frag_nxt;
  logic [PROTO_W-1:0]   proto_r, proto_nxt;
  logic [L4_W-1:0]      l4_r, l4_nxt;
  logic [LEN_W-1:0]     udp_r, udp_nxt;
  logic [TCP_OFF_W-1:0] tcp_r, tcp_nxt;
  logic [PORT_W-1:0]    port_r, port_nxt;
  dec_t                 dec_r, dec_nxt;

  logic                 snap_v_r, snap_v_nxt;
  eip_snap_t            snap_r, snap_nxt;

  logic                 accept;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     l3_pos;
  logic [CNT_W-1:0]     l4_pos;
  logic [15:0]          et_shift;
  logic [BYTE_W-1:0]    b;

  assign in_ch.ready = !(snap_v_r && out_full);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.frame_byte;
  assign pos         = cnt_r;
  assign l3_pos      = CNT_W'(l3_r);
  assign l4_pos      = CNT_W'(l4_r);
  assign et_shift    = {et_r[7:0], b};

  always_comb begin
    cnt_nxt   = (cnt_r != COUNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    et_nxt    = et_r;
    tag_nxt   = tag_r;
    l3_nxt    = l3_r;
    ihl_nxt   = ihl_r;
    total_nxt = total_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    l4_nxt    = l4_r;
    udp_nxt   = udp_r;
    tcp_nxt   = tcp_r;
    port_nxt  = port_r;
    dec_nxt   = dec_r;
    if (dec_r == DEC_NONE) begin
      if (pos == l3_pos - CNT_W'(2)) begin
        et_nxt = et_shift;
      end else if (pos == l3_pos - CNT_W'(1)) begin
        et_nxt = et_shift;
        if (et_shift == ET_CTAG || et_shift == ET_STAG) begin
          if (int'(tag_r) >= MAX_TAGS) begin
            dec_nxt = DEC_UNSUPPORTED;
          end else begin
            tag_nxt = tag_r + TAG_W'(1);
            l3_nxt  = l3_r + L3_W'(TAG_BYTES);
          end
        end else if (et_shift == ET_IPV6) begin
          l4_nxt = L4_W'(l3_r) + L4_W'(IPV6_HDR);
        end else if (et_shift != ET_IPV4) begin
          dec_nxt = DEC_UNSUPPORTED;
        end
      end else if (pos >= l3_pos) begin
        if (et_r == ET_IPV4) begin
          if (pos == l3_pos) begin
            if (b[7:4] != IP_VER4) begin
              dec_nxt = DEC_MALFORMED;
            end
            ihl_nxt = {b[3:0], 2'b00};
            l4_nxt  = L4_W'(l3_r) + L4_W'({b[3:0], 2'b00});
          end else if (pos == l3_pos + CNT_W'(V4_OFF_TOTAL) ||
                       pos == l3_pos + CNT_W'(V4_OFF_TOTAL + 1)) begin
            total_nxt = {total_r[7:0], b};
          end else if (pos == l3_pos + CNT_W'(V4_OFF_FRAG) ||
                       pos == l3_pos + CNT_W'(V4_OFF_FRAG + 1)) begin
            frag_nxt = {frag_r[FRAG_W-BYTE_W-1:0], b};
          end else if (pos == l3_pos + CNT_W'(V4_OFF_PROTO)) begin
            proto_nxt = b;
          end
        end else if (et_r == ET_IPV6) begin
          if (pos == l3_pos) begin
            if (b[7:4] != IP_VER6) begin
              dec_nxt = DEC_MALFORMED;
            end
          end else if (pos == l3_pos + CNT_W'(V6_OFF_PLEN) ||
                       pos == l3_pos + CNT_W'(V6_OFF_PLEN + 1)) begin
            total_nxt = {total_r[7:0], b};
          end else if (pos == l3_pos + CNT_W'(V6_OFF_NEXT)) begin
            proto_nxt = b;
          end
        end
      end
      if (dec_nxt == DEC_NONE && l4_r != '0 && pos >= l4_pos) begin
        if (pos == l4_pos + CNT_W'(L4_OFF_PORT) ||
            pos == l4_pos + CNT_W'(L4_OFF_PORT + 1)) begin
          port_nxt = {port_r[7:0], b};
        end else if (pos == l4_pos + CNT_W'(L4_OFF_LEN) ||
                     pos == l4_pos + CNT_W'(L4_OFF_LEN + 1)) begin
          udp_nxt = {udp_r[7:0], b};
        end else if (pos == l4_pos + CNT_W'(L4_OFF_TCPDO)) begin
          tcp_nxt = b[7:4];
        end
      end
    end
  end

  always_comb begin
    snap_nxt.len           = cnt_nxt;
    snap_nxt.l3_start      = l3_nxt;
    snap_nxt.decided       = dec_nxt;
    snap_nxt.is_v4         = (et_nxt == ET_IPV4);
    snap_nxt.is_v6         = (et_nxt == ET_IPV6);
    snap_nxt.ip_header_len = ihl_nxt;
    snap_nxt.ip_total_len  = total_nxt;
    snap_nxt.frag_nz       = |frag_nxt;
    snap_nxt.protocol      = proto_nxt;
    snap_nxt.udp_len       = udp_nxt;
    snap_nxt.tcp_offset    = tcp_nxt;
    snap_nxt.port          = port_nxt;
    snap_v_nxt             = snap_v_r;
    if (snap_take) begin
      snap_v_nxt = 1'b0;
    end
    if (accept && in_ch.last_byte) begin
      snap_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.last_byte)) begin
      cnt_r   <= '0;
      et_r    <= '0;
      tag_r   <= '0;
      l3_r    <= L3_W'(ETH_HDR_BYTES);
      ihl_r   <= '0;
      total_r <= '0;
      frag_r  <= '0;
      proto_r <= '0;
      l4_r    <= '0;
      udp_r   <= '0;
      tcp_r   <= '0;
      port_r  <= '0;
      dec_r   <= DEC_NONE;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      et_r    <= et_nxt;
      tag_r   <= tag_nxt;
      l3_r    <= l3_nxt;
      ihl_r   <= ihl_nxt;
      total_r <= total_nxt;
      frag_r  <= frag_nxt;
      proto_r <= proto_nxt;
      l4_r    <= l4_nxt;
      udp_r   <= udp_nxt;
      tcp_r   <= tcp_nxt;
      port_r  <= port_nxt;
      dec_r   <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_byte) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_v = snap_v_r;
  assign snap   = snap_r;

endmodule

/* src/eip_eval.sv */
module eip_eval import eip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      snap_v,
  input  eip_snap_t snap,
  output logic      snap_take,
  output logic      out_full,
  eip_out_if.source out_ch
);

  logic               out_v_r, out_v_nxt;
  status_t            st_r, st_nxt;
  logic [PROTO_W-1:0] proto_r, proto_nxt;
  logic [PORT_W-1:0]  port_r, port_nxt;
  logic [LEN_W-1:0]   poff_r, poff_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;

  logic [CNT_W-1:0]   off;
  logic [CNT_W-1:0]   room;
  logic [LEN_W-1:0]   span;
  logic [L4_W-1:0]    l4;
  logic [IHL_W-1:0]   tcp_hlen;
  logic [IHL_W-1:0]   l4_hdr;
  status_t            l4_st;
  status_t            st;

  assign off      = CNT_W'(snap.l3_start);
  assign room     = snap.len - off;
  assign span     = snap.is_v4 ? snap.ip_total_len - LEN_W'(snap.ip_header_len)
                               : snap.ip_total_len;
  assign l4       = snap.is_v4 ? L4_W'(snap.l3_start) + L4_W'(snap.ip_header_len)
                               : L4_W'(snap.l3_start) + L4_W'(IPV6_HDR);
  assign tcp_hlen = {snap.tcp_offset, 2'b00};
  assign l4_hdr   = (snap.protocol == PROTO_UDP) ? IHL_W'(UDP_HDR) : tcp_hlen;

  always_comb begin
    if (snap.protocol == PROTO_UDP) begin
      if (span < LEN_W'(UDP_HDR) || snap.udp_len < LEN_W'(UDP_HDR) ||
          snap.udp_len != span) begin
        l4_st = ST_MALFORMED;
      end else begin
        l4_st = ST_PARSED;
      end
    end else if (snap.protocol == PROTO_TCP) begin
      if (span < LEN_W'(TCP_MIN_HDR) || tcp_hlen < IHL_W'(TCP_MIN_HDR) ||
          LEN_W'(tcp_hlen) > span) begin
        l4_st = ST_MALFORMED;
      end else begin
        l4_st = ST_PARSED;
      end
    end else begin
      l4_st = ST_UNSUPPORTED;
    end
  end

  always_comb begin
    if (snap.len < CNT_W'(ETH_HDR_BYTES) || snap.len > CNT_W'(MAX_FRAME_BYTES)) begin
      st = ST_MALFORMED;
    end else if (snap.len < off) begin
      st = ST_MALFORMED;
    end else if (snap.decided != DEC_NONE) begin
      case (snap.decided)
        DEC_MALFORMED:   st = ST_MALFORMED;
        DEC_UNSUPPORTED: st = ST_UNSUPPORTED;
        default:         st = ST_MALFORMED;
      endcase
    end else if (snap.is_v4) begin
      if (room < CNT_W'(IPV4_MIN_HDR)) begin
        st = ST_MALFORMED;
      end else if (snap.ip_header_len < IHL_W'(IPV4_MIN_HDR) ||
                   snap.ip_total_len < LEN_W'(snap.ip_header_len) ||
                   CNT_W'(snap.ip_total_len) > room) begin
        st = ST_MALFORMED;
      end else if (snap.frag_nz) begin
        st = ST_UNSUPPORTED;
      end else begin
        st = l4_st;
      end
    end else if (snap.is_v6) begin
      if (room < CNT_W'(IPV6_HDR)) begin
        st = ST_MALFORMED;
      end else if (snap.ip_total_len == '0) begin
        st = ST_UNSUPPORTED;
      end else if (CNT_W'(snap.ip_total_len) > room - CNT_W'(IPV6_HDR)) begin
        st = ST_MALFORMED;
      end else begin
        st = l4_st;
      end
    end else begin
      st = ST_UNSUPPORTED;
    end
  end

  assign snap_take = snap_v && (!out_v_r || out_ch.ready);
  assign out_full  = out_v_r && !out_ch.ready;

  always_comb begin
    out_v_nxt = out_v_r;
    st_nxt    = st_r;
    proto_nxt = proto_r;
    port_nxt  = port_r;
    poff_nxt  = poff_r;
    plen_nxt  = plen_r;
    if (snap_take) begin
      out_v_nxt = 1'b1;
      st_nxt    = st;
      if (st == ST_PARSED) begin
        proto_nxt = snap.protocol;
        port_nxt  = snap.port;
        poff_nxt  = LEN_W'(l4) + LEN_W'(l4_hdr);
        plen_nxt  = span - LEN_W'(l4_hdr);
      end else begin
        proto_nxt = '0;
        port_nxt  = '0;
        poff_nxt  = '0;
        plen_nxt  = '0;
      end
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    proto_r <= proto_nxt;
    port_r  <= port_nxt;
    poff_r  <= poff_nxt;
    plen_r  <= plen_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = st_r;
  assign out_ch.l4_protocol    = proto_r;
  assign out_ch.dest_port      = port_r;
  assign out_ch.payload_offset = poff_r;
  assign out_ch.payload_length = plen_r;

endmodule

/* src/eth_ip_l4_header_parser.sv */
// Throughput: one frame byte per cycle; the input stalls only while a result waits
// in the output register and a second finished frame waits in the holding stage.
// Results: a frame's fields enter the holding stage at the edge that accepts its last
// byte, and its checked result is registered in the output register when that is free.
// Reset: rst_n low at a clock edge clears the frame state and both valid flags.
`include "eth_ip_l4_header_parser_assert.svh"

module eth_ip_l4_header_parser import eip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  eip_in_if.sink    in_ch,
  eip_out_if.source out_ch
);

  logic      snap_v;
  logic      snap_take;
  logic      out_full;
  eip_snap_t snap;
  logic      out_parsed;
  logic      proto_known;
  logic      fields_zero;

  eip_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_full  (out_full),
    .snap_take (snap_take),
    .snap_v    (snap_v),
    .snap      (snap)
  );

  eip_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_v    (snap_v),
    .snap      (snap),
    .snap_take (snap_take),
    .out_full  (out_full),
    .out_ch    (out_ch)
  );

  assign out_parsed  = (out_ch.status == ST_PARSED);
  assign proto_known = (out_ch.l4_protocol == PROTO_TCP) ||
                       (out_ch.l4_protocol == PROTO_UDP);
  assign fields_zero = (out_ch.dest_port == '0) && (out_ch.payload_offset == '0) &&
                       (out_ch.payload_length == '0) && (out_ch.l4_protocol == '0);

  `EIP_ASSERT_ALWAYS(a_out_from_snap, $rose(out_ch.valid) |-> $past(snap_v), "no frame")
  `EIP_ASSERT(a_snap_held, snap_v && !snap_take |=> snap_v, "held frame lost")
  `EIP_ASSERT(a_parsed_proto, out_ch.valid && out_parsed |-> proto_known, "bad protocol")
  `EIP_ASSERT(a_unparsed_zero, out_ch.valid && !out_parsed |-> fields_zero, "fields not cleared")

endmodule

/* tb/eth_ip_l4_header_parser_test.sv */
`timescale 1ns / 1ps

module eth_ip_l4_header_parser_test;
  import eip_pkg::*;

  typedef logic [7:0] frame_t[$];

  typedef struct packed {
    status_t            status;
    logic [PROTO_W-1:0] l4_protocol;
    logic [PORT_W-1:0]  dest_port;
    logic [LEN_W-1:0]   payload_offset;
    logic [LEN_W-1:0]   payload_length;
  } parse_verdict_t;

  logic clk;
  logic rst_n;

  eip_in_if  in_ch ();
  eip_out_if out_ch ();

  eth_ip_l4_header_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_verdict_t pending_verdicts[$];

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_cycles;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;

  // Frame state of the parser as the byte stream builds it up.
  int unsigned fr_count;
  int unsigned fr_etype;
  int unsigned fr_tags;
  int unsigned fr_l3;
  int unsigned fr_ihl;
  int unsigned fr_total;
  int unsigned fr_frag;
  int unsigned fr_proto;
  int unsigned fr_l4;
  int unsigned fr_udp_len;
  int unsigned fr_tcp_do;
  int unsigned fr_port;
  dec_t        fr_decided;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("eth_ip_l4_header_parser_test: FAIL");
    $finish;
  end

  function automatic void clear_frame_state();
    fr_count   = 0;
    fr_etype   = 0;
    fr_tags    = 0;
    fr_l3      = ETH_HDR_BYTES;
    fr_ihl     = 0;
    fr_total   = 0;
    fr_frag    = 0;
    fr_proto   = 0;
    fr_l4      = 0;
    fr_udp_len = 0;
    fr_tcp_do  = 0;
    fr_port    = 0;
    fr_decided = DEC_NONE;
  endfunction

  function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
    int unsigned    pos;
    int unsigned    off;
    int unsigned    lo;
    int unsigned    len;
    int unsigned    l4;
    int unsigned    ip_end;
    int unsigned    span;
    int unsigned    hlen;
    status_t        st;
    parse_verdict_t r;
    pos = fr_count;
    if (fr_count < COUNT_MAX) fr_count++;
    if (fr_decided == DEC_NONE) begin
      if (pos == fr_l3 - 2) begin
        fr_etype = ((fr_etype << 8) | b) & 16'hffff;
      end else if (pos == fr_l3 - 1) begin
        fr_etype = ((fr_etype << 8) | b) & 16'hffff;
        if (fr_etype == ET_CTAG || fr_etype == ET_STAG) begin
          if (fr_tags >= MAX_TAGS) begin
            fr_decided = DEC_UNSUPPORTED;
          end else begin
            fr_tags = (fr_tags + 1) & 3;
            fr_l3   = fr_l3 + TAG_BYTES;
          end
        end else if (fr_etype == ET_IPV6) begin
          fr_l4 = fr_l3 + IPV6_HDR;
        end else if (fr_etype != ET_IPV4) begin
          fr_decided = DEC_UNSUPPORTED;
        end
      end else if (pos >= fr_l3) begin
        off = pos - fr_l3;
        if (fr_etype == ET_IPV4) begin
          if (off == 0) begin
            if (b[7:4] != IP_VER4) fr_decided = DEC_MALFORMED;
            fr_ihl = 32'(b[3:0]) * 4;
            fr_l4  = fr_l3 + fr_ihl;
          end else if (off == V4_OFF_TOTAL || off == V4_OFF_TOTAL + 1) begin
            fr_total = ((fr_total << 8) | b) & 16'hffff;
          end else if (off == V4_OFF_FRAG || off == V4_OFF_FRAG + 1) begin
            fr_frag = ((fr_frag << 8) | b) & 14'h3fff;
          end else if (off == V4_OFF_PROTO) begin
            fr_proto = 32'(b);
          end
        end else if (fr_etype == ET_IPV6) begin
          if (off == 0) begin
            if (b[7:4] != IP_VER6) fr_decided = DEC_MALFORMED;
          end else if (off == V6_OFF_PLEN || off == V6_OFF_PLEN + 1) begin
            fr_total = ((fr_total << 8) | b) & 16'hffff;
          end else if (off == V6_OFF_NEXT) begin
            fr_proto = 32'(b);
          end
        end
      end
      if (fr_decided == DEC_NONE && fr_l4 != 0 && pos >= fr_l4) begin
        lo = pos - fr_l4;
        if (lo == L4_OFF_PORT || lo == L4_OFF_PORT + 1) begin
          fr_port = ((fr_port << 8) | b) & 16'hffff;
        end else if (lo == L4_OFF_LEN || lo == L4_OFF_LEN + 1) begin
          fr_udp_len = ((fr_udp_len << 8) | b) & 16'hffff;
        end else if (lo == L4_OFF_TCPDO) begin
          fr_tcp_do = 32'(b[7:4]);
        end
      end
    end
    if (last) begin
      len  = fr_count;
      st   = ST_PARSED;
      l4   = 0;
      hlen = 0;
      span = 0;
      if (len < ETH_HDR_BYTES || len > MAX_FRAME_BYTES || len < fr_l3) begin
        st = ST_MALFORMED;
      end else if (fr_decided != DEC_NONE) begin
        st = (fr_decided == DEC_MALFORMED) ? ST_MALFORMED : ST_UNSUPPORTED;
      end else if (fr_etype == ET_IPV4 && (len < fr_l3 + IPV4_MIN_HDR ||
                   fr_ihl < IPV4_MIN_HDR || fr_total < fr_ihl || fr_total > len - fr_l3)) begin
        st = ST_MALFORMED;
      end else if (fr_etype == ET_IPV4 && fr_frag != 0) begin
        st = ST_UNSUPPORTED;
      end else if (fr_etype == ET_IPV6 && len < fr_l3 + IPV6_HDR) begin
        st = ST_MALFORMED;
      end else if (fr_etype == ET_IPV6 && fr_total == 0) begin
        st = ST_UNSUPPORTED;
      end else if (fr_etype == ET_IPV6 && fr_total > len - fr_l3 - IPV6_HDR) begin
        st = ST_MALFORMED;
      end else if (fr_etype != ET_IPV4 && fr_etype != ET_IPV6) begin
        st = ST_UNSUPPORTED;
      end else begin
        if (fr_etype == ET_IPV4) begin
          l4     = fr_l3 + fr_ihl;
          ip_end = fr_l3 + fr_total;
        end else begin
          l4     = fr_l3 + IPV6_HDR;
          ip_end = l4 + fr_total;
        end
        span = ip_end - l4;
        if (fr_proto == PROTO_UDP) begin
          hlen = UDP_HDR;
          if (span < UDP_HDR || fr_udp_len < UDP_HDR || fr_udp_len != span) st = ST_MALFORMED;
        end else if (fr_proto == PROTO_TCP) begin
          hlen = fr_tcp_do * 4;
          if (span < TCP_MIN_HDR || hlen < TCP_MIN_HDR || hlen > span) st = ST_MALFORMED;
        end else begin
          st = ST_UNSUPPORTED;
        end
      end
      r = '0;
      r.status = st;
      if (st == ST_PARSED) begin
        r.l4_protocol    = 8'(fr_proto);
        r.dest_port      = 16'(fr_port);
        r.payload_offset = 16'(l4 + hlen);
        r.payload_length = 16'(span - hlen);
      end
      pending_verdicts.push_back(r);
      clear_frame_state();
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    parse_verdict_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no frame pending, status %0h", out_ch.status));
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 16'(out_ch.status), 16'(want.status));
        check_field("l4_protocol", 16'(out_ch.l4_protocol), 16'(want.l4_protocol));
        check_field("dest_port", out_ch.dest_port, want.dest_port);
        check_field("payload_offset", out_ch.payload_offset, want.payload_offset);
        check_field("payload_length", out_ch.payload_length, want.payload_length);
        results_seen++;
      end
    end
  end

  // The receiver either holds off for a counted stretch or stalls at random.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready   <= 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.last_byte  <= last;
    forever begin
      @(posedge clk);
      if (in_ch.ready === 1'b1) break;
    end
    bytes_sent++;
    parse_frame_byte(b, last);
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // The sender stops offering items until every frame sent has its result.
  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_verdicts.size() == 0);
  endtask

  function automatic frame_t random_bytes(input int n);
    frame_t f;
    repeat (n) f.push_back(8'($urandom));
    return f;
  endfunction

  function automatic void push16(ref frame_t f, input logic [15:0] v);
    f.push_back(v[15:8]);
    f.push_back(v[7:0]);
  endfunction

  function automatic void put16(ref frame_t f, input int idx, input logic [15:0] v);
    f[idx]     = v[15:8];
    f[idx + 1] = v[7:0];
  endfunction

  function automatic frame_t build_frame(input int tags, input bit v6, input logic [7:0] proto,
                                         input int l4_len, input int ihl_words,
                                         input int tcp_words, input logic [15:0] dport,
                                         input int pad);
    frame_t f;
    frame_t seg;
    f = random_bytes(12);
    repeat (tags) begin
      push16(f, $urandom_range(1) ? ET_STAG : ET_CTAG);
      push16(f, 16'($urandom));
    end
    if (v6) begin
      push16(f, ET_IPV6);
      f.push_back({IP_VER6, 4'($urandom)});
      repeat (3) f.push_back(8'($urandom));
      push16(f, 16'(l4_len));
      f.push_back(proto);
      repeat (33) f.push_back(8'($urandom));
    end else begin
      push16(f, ET_IPV4);
      f.push_back({IP_VER4, 4'(ihl_words)});
      f.push_back(8'($urandom));
      push16(f, 16'(ihl_words * 4 + l4_len));
      push16(f, 16'($urandom));
      push16(f, {2'($urandom), 14'd0});
      f.push_back(8'($urandom));
      f.push_back(proto);
      repeat (ihl_words * 4 - 10) f.push_back(8'($urandom));
    end
    seg = random_bytes(l4_len < 24 ? 24 : l4_len);
    put16(seg, L4_OFF_PORT, dport);
    if (proto == PROTO_UDP) put16(seg, L4_OFF_LEN, 16'(l4_len));
    if (proto == PROTO_TCP) seg[L4_OFF_TCPDO] = {4'(tcp_words), 4'($urandom)};
    for (int i = 0; i < l4_len; i++) f.push_back(seg[i]);
    repeat (pad) f.push_back(8'($urandom));
    return f;
  endfunction

  // Mostly well-formed frames with random content; the rest are damaged or junk.
  function automatic frame_t random_frame();
    frame_t     f;
    int         sel;
    int         tags;
    int         tcp_words;
    int         l4_len;
    int         cut;
    bit         v6;
    logic [7:0] proto;
    sel       = $urandom_range(99);
    tags      = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
    v6        = 1'($urandom);
    tcp_words = $urandom_range(5, 15);
    case ($urandom_range(9))
      0: begin
        proto  = 8'($urandom);
        l4_len = $urandom_range(0, 30);
      end
      1, 2, 3, 4: begin
        proto  = PROTO_UDP;
        l4_len = $urandom_range(8, 40);
      end
      default: begin
        proto  = PROTO_TCP;
        l4_len = tcp_words * 4 + $urandom_range(0, 20);
      end
    endcase
    f = build_frame(tags, v6, proto, l4_len,
                    ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5,
                    tcp_words, 16'($urandom),
                    ($urandom_range(2) == 0) ? $urandom_range(1, 12) : 0);
    if (!v6 && $urandom_range(14) == 0) f[ETH_HDR_BYTES + 4 * tags + V4_OFF_FRAG] |= 8'h20;
    if (sel >= 95) begin
      f = random_bytes($urandom_range(1, 80));
    end else if (sel >= 85) begin
      f = f[0:$urandom_range(0, f.size() - 1)];
    end else if (sel >= 70) begin
      cut    = $urandom_range(12, (f.size() < 70 ? f.size() : 70) - 1);
      f[cut] = 8'($urandom);
    end
    return f;
  endfunction

  task automatic test_well_formed_frames();
    frame_t f;
    send_frame(build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'h0000, 10));
    send_frame(build_frame(1, 0, PROTO_TCP, 20, 5, 5, 16'hffff, 0));
    send_frame(build_frame(2, 0, PROTO_TCP, 60, 15, 15, 16'($urandom), 3));
    send_frame(build_frame(2, 1, PROTO_UDP, 30, 5, 5, 16'($urandom), 0));
    send_frame(build_frame(0, 1, PROTO_TCP, 50, 5, 8, 16'($urandom), 4));
    send_frame(build_frame(1, 1, PROTO_UDP, 8, 5, 5, 16'($urandom), 7));
    // The reserved and don't-fragment bits lie outside the fragment mask.
    f = build_frame(0, 0, PROTO_UDP, 12, 5, 5, 16'($urandom), 0);
    f[20] = 8'hc0;
    send_frame(f);
    wait_all_results();
  endtask

  task automatic test_header_faults();
    frame_t f;
    send_frame(random_bytes(1));
    send_frame(random_bytes(13));
    f = random_bytes(14);
    foreach (f[i]) f[i] = 8'h00;
    send_frame(f);
    f = random_bytes(15);
    foreach (f[i]) f[i] = 8'hff;
    send_frame(f);
    f = build_frame(1, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    send_frame(f[0:15]);
    send_frame(build_frame(3, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0));
    f = build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    put16(f, 12, 16'h0806);
    send_frame(f);
    f = build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    f[14] = 8'h65;
    send_frame(f);
    f = build_frame(0, 1, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    f[14] = 8'h45;
    send_frame(f);
    f = build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    send_frame(f[0:32]);
    f[14] = 8'h44;
    send_frame(f);
    f[14] = 8'h40;
    send_frame(f);
    f = build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    put16(f, 16, 16'd19);
    send_frame(f);
    put16(f, 16, 16'd29);
    send_frame(f);
    f = build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 4);
    f[20] = 8'h20;
    send_frame(f);
    f[20] = 8'h00;
    f[21] = 8'h01;
    send_frame(f);
    f = build_frame(0, 1, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    send_frame(f[0:52]);
    put16(f, 18, 16'd0);
    send_frame(f);
    put16(f, 18, 16'd9);
    send_frame(f);
    send_frame(build_frame(0, 0, PROTO_UDP, 7, 5, 5, 16'($urandom), 0));
    f = build_frame(0, 0, PROTO_UDP, 8, 5, 5, 16'($urandom), 0);
    put16(f, 38, 16'd0);
    send_frame(f);
    f = build_frame(0, 0, PROTO_UDP, 20, 5, 5, 16'($urandom), 2);
    put16(f, 38, 16'd19);
    send_frame(f);
    send_frame(build_frame(0, 0, PROTO_TCP, 19, 5, 5, 16'($urandom), 0));
    send_frame(build_frame(0, 0, PROTO_TCP, 20, 5, 4, 16'($urandom), 0));
    send_frame(build_frame(0, 0, PROTO_TCP, 30, 5, 10, 16'($urandom), 0));
    send_frame(build_frame(0, 0, 8'd1, 8, 5, 5, 16'($urandom), 0));
    send_frame(build_frame(0, 1, 8'd58, 8, 5, 5, 16'($urandom), 0));
    wait_all_results();
  endtask

  // Short frames keep arriving while the receiver holds off, so the parser
  // fills up and has to stall its input.
  task automatic test_output_backpressure();
    rx_hold_cycles = 400;
    repeat (10) send_frame(random_bytes(14));
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int unsigned first_byte;
    int unsigned first_frame;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first_byte  = bytes_sent;
    first_frame = frames_sent;
    while (bytes_sent - first_byte < 100 || frames_sent - first_frame < 2) begin
      send_frame(random_frame());
      if ($urandom_range(14) == 0) wait_all_results();
    end
    wait_all_results();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = '0;
    in_ch.last_byte  = 1'b0;
    tx_idle_pct      = 29;
    rx_idle_pct      = 57;
    rx_hold_cycles   = 0;
    bytes_sent       = 0;
    frames_sent      = 0;
    results_seen     = 0;
    mismatch_count   = 0;
    clear_frame_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_well_formed_frames();
    test_header_faults();
    test_output_backpressure();
    test_random_traffic(29, 57);
    test_random_traffic(57, 29);
    test_random_traffic(0, 0);

    wait_all_results();
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
    end
    if (mismatch_count == 0) begin
      $display("eth_ip_l4_header_parser_test: PASS");
    end else begin
      $display("eth_ip_l4_header_parser_test: FAIL");
    end
    $finish;
  end

endmodule
